// ===== design/ebwd_pkg.sv =====
// Shared types, codes and constants of the event block word decoder.
`default_nettype none
package ebwd_pkg;

  localparam int unsigned BlockWordsDef = 32768;
  localparam int unsigned ResDepth      = 4;

  localparam logic [15:0] MarkEvent   = 16'hFFFF;
  localparam logic [15:0] SignAdc     = 16'h4800;
  localparam logic [15:0] SignStamp   = 16'h8000;
  localparam logic [15:0] SignEnd     = 16'h5E00;
  localparam logic [15:0] MarkEnd     = 16'h5E5E;
  localparam logic [15:0] MarkStamp2  = 16'h270F;
  localparam logic [15:0] MaskLow     = 16'h00FF;
  localparam logic [15:0] MaskHigh    = 16'hFF00;

  localparam logic [1:0] CfgHeaderWords = 2'd0;
  localparam logic [1:0] CfgMaxModule   = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEAD     = 3'd1,
    PH_SIZE     = 3'd2,
    PH_REC      = 3'd3,
    PH_PEND_TS  = 3'd4,
    PH_PEND_END = 3'd5,
    PH_ADC      = 3'd6,
    PH_STAMP    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_HIT = 3'd0,
    K_TS  = 3'd1,
    K_EVT = 3'd2,
    K_BLK = 3'd3,
    K_ERR = 3'd4
  } kind_e;

  typedef struct packed {
    logic [15:0] word;
    logic        block_start;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] channel;
    logic [15:0] adc_value;
    logic [15:0] cfd_value;
    logic [51:0] timestamp;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [14:0] header_words;
    logic [7:0]  max_module;
  } cfg_t;

  // Up to two results decoded from one word.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_res_t;

endpackage
`default_nettype wire

// ===== design/ebwd_decode.sv =====
// Word decoder: parse state and the per-word result logic.
`default_nettype none
module ebwd_decode #(
  parameter int unsigned BlockWords = ebwd_pkg::BlockWordsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire ebwd_pkg::in_beat_t beat_i,
  input  wire ebwd_pkg::cfg_t     cfg_i,
  output ebwd_pkg::dec_res_t      res_o
);

  ebwd_pkg::phase_e phase_q, phase_d;
  logic [15:0] word_count_q, word_count_d;
  logic [15:0] ewl_q, ewl_d;
  logic [3:0]  rec_pos_q, rec_pos_d;
  logic [7:0]  module_q, module_d;
  logic [7:0]  swl_q, swl_d;
  logic [15:0] adc_hold_q [4];
  logic [15:0] stamp_ch_q, stamp_hi_q, stamp_mid_q;
  logic        adc_we, ch_we, hi_we, mid_we;
  logic [1:0]  adc_wa;

  always_comb begin
    ebwd_pkg::phase_e ph;
    logic [15:0] w, pos, ewl_c;
    logic [14:0] half;
    logic [1:0]  k, sp;
    logic [3:0]  p, pk;
    logic [47:0] t48;
    logic        have_a, have_evt, end_rec;
    ebwd_pkg::res_t ra, re;

    w   = beat_i.word;
    ph  = beat_i.block_start ? ebwd_pkg::PH_HEAD : phase_q;
    pos = beat_i.block_start ? 16'd0 : word_count_q;
    ewl_c = (ewl_q != 16'd0) ? ewl_q - 16'd1 : 16'd0;
    half  = w[15:1];
    p     = rec_pos_q;
    pk    = p - 4'd5;
    k     = pk[1:0];
    sp    = rec_pos_q[1:0];
    t48   = {stamp_hi_q, stamp_mid_q, w};

    phase_d      = ph;
    word_count_d = pos;
    ewl_d        = ewl_q;
    rec_pos_d    = rec_pos_q;
    module_d     = module_q;
    swl_d        = swl_q;
    adc_we = 1'b0; ch_we = 1'b0; hi_we = 1'b0; mid_we = 1'b0;
    adc_wa = p[1:0] - 2'd1;
    have_a = 1'b0; end_rec = 1'b0;
    ra = '0;
    re = '0;
    re.kind = ebwd_pkg::K_EVT;
    have_evt = 1'b0;

    if (ph != ebwd_pkg::PH_IDLE) begin
      if (pos != 16'hFFFF) word_count_d = pos + 16'd1;
      if ({1'b0, pos} >= 17'(BlockWords)) begin
        have_a = 1'b1; ra.kind = ebwd_pkg::K_ERR; phase_d = ebwd_pkg::PH_IDLE;
      end else begin
        unique case (ph)
          ebwd_pkg::PH_HEAD: begin
            if (pos >= {1'b0, cfg_i.header_words}) begin
              if (w != ebwd_pkg::MarkEvent) begin
                have_a = 1'b1; ra.kind = ebwd_pkg::K_BLK; phase_d = ebwd_pkg::PH_IDLE;
              end else begin
                phase_d = ebwd_pkg::PH_SIZE;
              end
            end
          end
          ebwd_pkg::PH_SIZE: begin
            if (half == 15'd2) begin
              have_a = 1'b1; ra.kind = ebwd_pkg::K_BLK; phase_d = ebwd_pkg::PH_IDLE;
            end else if (half < 15'd2) begin
              have_evt = 1'b1; phase_d = ebwd_pkg::PH_HEAD;
            end else begin
              ewl_d = {1'b0, half - 15'd2}; phase_d = ebwd_pkg::PH_REC;
            end
          end
          ebwd_pkg::PH_REC: begin
            ewl_d = ewl_c;
            if ((w & ebwd_pkg::MaskHigh) == ebwd_pkg::SignAdc && w[7:0] != 8'd0 &&
                w[7:0] <= cfg_i.max_module) begin
              module_d = w[7:0]; rec_pos_d = 4'd1; phase_d = ebwd_pkg::PH_ADC;
            end else if ((w & ebwd_pkg::MaskHigh) == ebwd_pkg::SignStamp) begin
              module_d = w[7:0]; phase_d = ebwd_pkg::PH_PEND_TS;
            end else if (w == ebwd_pkg::MarkEnd) begin
              phase_d = ebwd_pkg::PH_PEND_END;
            end else begin
              have_a = 1'b1; ra.kind = ebwd_pkg::K_ERR; phase_d = ebwd_pkg::PH_IDLE;
            end
          end
          ebwd_pkg::PH_PEND_TS: begin
            ewl_d = ewl_c;
            if (w == ebwd_pkg::MarkStamp2) begin
              swl_d = module_q; rec_pos_d = 4'd0;
              if (module_q == 8'd0) end_rec = 1'b1;
              else phase_d = ebwd_pkg::PH_STAMP;
            end else begin
              have_a = 1'b1; ra.kind = ebwd_pkg::K_ERR; phase_d = ebwd_pkg::PH_IDLE;
            end
          end
          ebwd_pkg::PH_PEND_END: begin
            have_a = 1'b1;
            ra.kind = (w == ebwd_pkg::MarkEnd) ? ebwd_pkg::K_BLK : ebwd_pkg::K_ERR;
            phase_d = ebwd_pkg::PH_IDLE;
          end
          ebwd_pkg::PH_ADC: begin
            ewl_d = ewl_c;
            if (p >= 4'd1 && p <= 4'd4) begin
              adc_we = 1'b1;
            end else if (p >= 4'd5 && p <= 4'd8) begin
              if (adc_hold_q[k] != 16'd0) begin
                have_a = 1'b1;
                ra.kind      = ebwd_pkg::K_HIT;
                ra.channel   = {module_q, 3'b000, k, 3'b000};
                ra.adc_value = adc_hold_q[k];
                ra.cfd_value = w;
              end
            end
            if (p >= 4'd9 || p == 4'd0) end_rec = 1'b1;
            else rec_pos_d = p + 4'd1;
          end
          ebwd_pkg::PH_STAMP: begin
            ewl_d = ewl_c;
            ch_we  = (sp == 2'd0);
            hi_we  = (sp == 2'd1);
            mid_we = (sp == 2'd2);
            if (sp == 2'd3) begin
              have_a = 1'b1;
              ra.kind      = ebwd_pkg::K_TS;
              ra.channel   = stamp_ch_q;
              ra.timestamp = 52'({t48, 3'b000}) + 52'({t48, 1'b0});
              swl_d = (swl_q > 8'd4) ? swl_q - 8'd4 : 8'd0;
              rec_pos_d = 4'd0;
              if (swl_d == 8'd0) end_rec = 1'b1;
            end else begin
              rec_pos_d = {2'b00, sp + 2'd1};
            end
          end
          default: phase_d = ebwd_pkg::PH_IDLE;
        endcase
      end
    end

    // Record finished: close the event once its word budget is spent.
    if (end_rec) begin
      if (ewl_c == 16'd0) begin
        have_evt = 1'b1; phase_d = ebwd_pkg::PH_HEAD;
      end else begin
        phase_d = ebwd_pkg::PH_REC;
      end
    end

    res_o.n  = {1'b0, have_a} + {1'b0, have_evt};
    re.last  = 1'b1;
    ra.last  = !have_evt;
    res_o.r0 = have_a ? ra : re;
    res_o.r1 = re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ebwd_pkg::PH_IDLE;
      word_count_q <= '0;
      ewl_q        <= '0;
      rec_pos_q    <= '0;
      module_q     <= '0;
      swl_q        <= '0;
    end else if (take_i) begin
      phase_q      <= phase_d;
      word_count_q <= word_count_d;
      ewl_q        <= ewl_d;
      rec_pos_q    <= rec_pos_d;
      module_q     <= module_d;
      swl_q        <= swl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && adc_we) adc_hold_q[adc_wa] <= beat_i.word;
    if (take_i && ch_we)  stamp_ch_q  <= {beat_i.word[7:0], beat_i.word[15:8]};
    if (take_i && hi_we)  stamp_hi_q  <= beat_i.word;
    if (take_i && mid_we) stamp_mid_q <= beat_i.word;
  end

endmodule
`default_nettype wire

// ===== design/ebwd_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while the reader is ready.
`default_nettype none
module ebwd_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ebwd_pkg::dec_res_t res_i,
  output logic                    space_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ebwd_pkg::res_t          out_beat_o
);

  localparam int unsigned PtrW = $clog2(ebwd_pkg::ResDepth);
  localparam int unsigned CntW = PtrW + 1;

  ebwd_pkg::res_t mem_q [ebwd_pkg::ResDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      n_push;
  logic            pop;

  // Room for a full two-result beat.
  assign space_o     = count_q <= CntW'(ebwd_pkg::ResDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_beat_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = push_i ? res_i.n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(n_push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_ptr_q] <= res_i.r0;
    if (n_push == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= res_i.r1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ebwd_pkg::ResDepth))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> space_o)
    else $error("push without room");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd2 && !pop) |=> count_q == $past(count_q) + CntW'(2))
    else $error("count lost a pair push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != CntW'(ebwd_pkg::ResDepth) |->
      PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
    else $error("pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== design/event_block_word_decoder.sv =====
// Top level of the event block word decoder: input register, decoder, result queue.
//
//  channel  dir  handshake                 beat
//  in       in   in_valid_i / in_ready_o   in_beat_i  (word, block_start)
//  out      out  out_valid_o / out_ready_i out_beat_o (kind .. timestamp, last)
//  cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle while the queue has room; a taken word is held in the input
// register, then decoded into the result queue that drives the output. A word
// that yields two results (record plus event end) needs two output beats, so a long run
// of such words is paced by the one-beat-per-cycle read of the four-entry result queue.
// Reset clears the parse state and queue and sets the configuration to defaults; no clearing pass.
// Output stalls back up through the queue into the input register.
`default_nettype none
module event_block_word_decoder #(
  parameter int unsigned BlockWords = ebwd_pkg::BlockWordsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ebwd_pkg::in_beat_t in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ebwd_pkg::res_t          out_beat_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  ebwd_pkg::in_beat_t in_q;
  logic               in_valid_q;
  ebwd_pkg::cfg_t     cfg_q;
  ebwd_pkg::dec_res_t dec_res;
  logic               space;
  logic               advance;

  // The held word is decoded once the queue can take both its results.
  assign advance     = in_valid_q && space;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_beat_i;
  end

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_words <= 15'd0;
      cfg_q.max_module   <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ebwd_pkg::CfgHeaderWords: cfg_q.header_words <= cfg_data_i[14:0];
        ebwd_pkg::CfgMaxModule:   cfg_q.max_module   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ebwd_decode #(
    .BlockWords(BlockWords)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (advance),
    .beat_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (dec_res)
  );

  ebwd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .res_i       (dec_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire
